// File: rtl/core/hsd_pkg.sv
// shared constants, status codes and position helpers for the secded decoder
package hsd_pkg;

	// default code geometry, (64,57) extended hamming
	localparam int PARITY_BITS_DEF = 6;
	localparam int CODE_LEN_DEF    = 64;
	localparam int DATA_LEN_DEF    = 57;
	localparam int MAX_CODE_LEN    = 64;

	// decode outcome
	typedef enum logic [1:0] {
		ST_CLEAN  = 2'd0,
		ST_CORR   = 2'd1,
		ST_CHECK  = 2'd2,
		ST_DOUBLE = 2'd3
	} status_t;

	// true for positions that hold a check bit
	function automatic bit is_pow2(input int p);
		return (p != 0) && ((p & (p - 1)) == 0);
	endfunction

	function automatic int floor_log2(input int p);
		int r;
		int v;
		r = 0;
		v = p;
		while (v > 1) begin
			v = v >> 1;
			r = r + 1;
		end
		return r;
	endfunction

	// data slot of a non-check position
	function automatic int data_slot(input int p);
		return p - floor_log2(p) - 2;
	endfunction

	// codeword position that carries a given data slot
	function automatic int slot_pos(input int s);
		int r;
		r = 2 * MAX_CODE_LEN;
		for (int p = 2 * MAX_CODE_LEN - 1; p >= 3; p--) begin
			if (!is_pow2(p) && data_slot(p) == s) begin
				r = p;
			end
		end
		return r;
	endfunction

	// positions whose index has a given bit set, bit 0 excluded
	function automatic logic [MAX_CODE_LEN-1:0] pos_mask(input int b);
		logic [MAX_CODE_LEN-1:0] m;
		m = '0;
		for (int p = 1; p < MAX_CODE_LEN; p++) begin
			m[p] = ((p >> b) & 1) != 0;
		end
		return m;
	endfunction

endpackage

// File: rtl/core/hamming_secded_decoder.sv
// extended hamming secded decoder, three register stages
// a request taken into the input register passes the syndrome and output stages, then is strobed on done
// throughput: one request per cycle; busy stays low, every stage advances each cycle
// done marks each result for one cycle; the receiver cannot stall
// reset: arst_n clears all stage valid bits at once, payload registers are not reset
module hamming_secded_decoder #(
	parameter int PARITY_BITS = hsd_pkg::PARITY_BITS_DEF,
	parameter int CODE_LEN    = hsd_pkg::CODE_LEN_DEF,
	parameter int DATA_LEN    = hsd_pkg::DATA_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [CODE_LEN-1:0] codeword,
	output logic                done,
	output logic [DATA_LEN-1:0] data_word,
	output logic [1:0]          status
);
	import hsd_pkg::*;

	logic                   valid_s1;
	logic [CODE_LEN-1:0]    cw_s1;
	logic                   valid_s2;
	logic [PARITY_BITS-1:0] syn_s2;
	logic                   par_s2;
	logic [DATA_LEN-1:0]    data_s2;
	logic                   valid_s3;
	logic [DATA_LEN-1:0]    data_s3;
	status_t                status_s3;

	logic [PARITY_BITS-1:0] syn_c;
	logic                   par_c;
	logic [DATA_LEN-1:0]    data_c;
	logic [DATA_LEN-1:0]    fix_data;
	status_t                fix_status;

	// a new request every cycle
	assign busy = 1'b0;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cw_s1 <= codeword;
		end
	end

	// syndrome bits as parity over fixed position masks
	for (genvar b = 0; b < PARITY_BITS; b++) begin : g_syn
		localparam logic [MAX_CODE_LEN-1:0] MASK = pos_mask(b);
		assign syn_c[b] = ^(cw_s1 & MASK[CODE_LEN-1:0]);
	end

	// overall parity
	assign par_c = ^cw_s1;

	// data extraction
	for (genvar s = 0; s < DATA_LEN; s++) begin : g_data
		localparam int POS = slot_pos(s);
		if (POS < CODE_LEN) begin : g_bit
			assign data_c[s] = cw_s1[POS];
		end else begin : g_zero
			assign data_c[s] = 1'b0;
		end
	end

	// syndrome stage
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			syn_s2  <= syn_c;
			par_s2  <= par_c;
			data_s2 <= data_c;
		end
	end

	hsd_fix #(
		.PARITY_BITS(PARITY_BITS),
		.CODE_LEN   (CODE_LEN),
		.DATA_LEN   (DATA_LEN)
	) u_fix (
		.syn     (syn_s2),
		.par     (par_s2),
		.data_in (data_s2),
		.data_out(fix_data),
		.status  (fix_status)
	);

	// output stage
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			data_s3   <= fix_data;
			status_s3 <= fix_status;
		end
	end

	assign done      = valid_s3;
	assign data_word = data_s3;
	assign status    = status_s3;

`ifndef SYNTHESIS
	// every result comes from an earlier request on start
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3))
		else $error("result without a matching request");

	// zero syndrome always decodes clean
	a_zero_syn_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && syn_s2 == '0) |=> (status == ST_CLEAN))
		else $error("zero syndrome not reported clean");

	// nonzero syndrome with even parity is a double error
	a_even_double: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !par_s2 && syn_s2 != '0) |=> (status == ST_DOUBLE))
		else $error("even parity error not reported double");

	// data only changes when a correction is reported
	a_data_untouched: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_CORR) |-> (data_word == $past(data_s2)))
		else $error("data altered without a correction");
`endif

endmodule

// File: rtl/core/hsd_fix.sv
// syndrome decode: classifies the error and flips the addressed data bit
module hsd_fix #(
	parameter int PARITY_BITS = hsd_pkg::PARITY_BITS_DEF,
	parameter int CODE_LEN    = hsd_pkg::CODE_LEN_DEF,
	parameter int DATA_LEN    = hsd_pkg::DATA_LEN_DEF
) (
	input  logic [PARITY_BITS-1:0] syn,
	input  logic                   par,
	input  logic [DATA_LEN-1:0]    data_in,
	output logic [DATA_LEN-1:0]    data_out,
	output hsd_pkg::status_t       status
);
	import hsd_pkg::*;

	logic [DATA_LEN-1:0] flip;
	logic                hit;

	// one syndrome compare per data slot
	for (genvar s = 0; s < DATA_LEN; s++) begin : g_flip
		localparam int POS = slot_pos(s);
		if (POS < CODE_LEN && POS < (1 << PARITY_BITS)) begin : g_hit
			localparam logic [PARITY_BITS-1:0] POS_SYN = PARITY_BITS'(POS);
			assign flip[s] = (syn == POS_SYN);
		end else begin : g_none
			assign flip[s] = 1'b0;
		end
	end

	assign hit = |flip;

	// classify the syndrome
	always_comb begin
		if (syn == '0) begin
			status = ST_CLEAN;
		end else if (!par) begin
			status = ST_DOUBLE;
		end else if ($onehot(syn)) begin
			status = ST_CHECK;
		end else if (hit) begin
			status = ST_CORR;
		end else begin
			status = ST_DOUBLE;
		end
	end

	// correct only on a single data error
	assign data_out = (status == ST_CORR) ? (data_in ^ flip) : data_in;

endmodule

// File: verif/hamming_secded_checker.sv
// checker for the secded decoder: watches requests and results, predicts and compares
`timescale 1ns / 1ps

module hamming_secded_checker #(
	parameter int CODE_LEN = hsd_pkg::CODE_LEN_DEF,
	parameter int DATA_LEN = hsd_pkg::DATA_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [CODE_LEN-1:0] codeword,
	input  logic                done,
	input  logic [DATA_LEN-1:0] data_word,
	input  logic [1:0]          status,
	output int                  fail_count,
	output int                  pending
);

	import hsd_pkg::*;

	typedef struct {
		logic [DATA_LEN-1:0] data;
		status_t             st;
	} decoded_t;

	decoded_t decode_queue[$];

	// a check bit sits at every power-of-two position
	function automatic bit check_position(input int p);
		return (p > 0) && ((p & (p - 1)) == 0);
	endfunction

	// syndrome, overall parity and correction of one received word
	function automatic decoded_t secded_outcome(input logic [CODE_LEN-1:0] cw);
		decoded_t r;
		int       syn;
		bit       par;
		int       slot;
		int       slot_of[CODE_LEN];
		r.data = '0;
		r.st = ST_CLEAN;
		syn = 0;
		par = cw[0];
		slot = 0;
		slot_of[0] = -1;
		for (int p = 1; p < CODE_LEN; p++) begin
			if (check_position(p)) begin
				slot_of[p] = -1;
			end else begin
				slot_of[p] = slot;
				slot++;
			end
			if (cw[p]) begin
				syn ^= p;
				par ^= 1'b1;
				if (slot_of[p] >= 0 && slot_of[p] < DATA_LEN) begin
					r.data[slot_of[p]] = 1'b1;
				end
			end
		end
		// zero syndrome passes as clean whatever the parity
		if (syn != 0) begin
			if (!par) begin
				r.st = ST_DOUBLE;
			end else if (check_position(syn)) begin
				r.st = ST_CHECK;
			end else begin
				r.st = ST_DOUBLE;
				if (syn < CODE_LEN) begin
					if (slot_of[syn] < DATA_LEN) begin
						r.data[slot_of[syn]] = ~r.data[slot_of[syn]];
						r.st = ST_CORR;
					end
				end
			end
		end
		return r;
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// compare results, then record accepted requests
	always @(posedge clk) begin
		decoded_t want;
		if (arst_n) begin
			if (done) begin
				if (decode_queue.size() == 0) begin
					$display("%0t unexpected result: expected none, %s %h status %0d",
						$time, "actual data_word", data_word, status);
					fail_count <= fail_count + 1;
				end else begin
					want = decode_queue.pop_front();
					if (data_word !== want.data || status !== want.st) begin
						$display("%0t mismatch: expected data_word %h status %0d,",
							$time, want.data, want.st);
						$display("    actual data_word %h status %0d",
							data_word, status);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) begin
				decode_queue.push_back(secded_outcome(codeword));
			end
			pending <= decode_queue.size();
		end
	end

endmodule

// File: verif/hamming_secded_decoder_test.sv
// top of the secded decoder testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module hamming_secded_decoder_test;

	import hsd_pkg::*;

	localparam int CW = CODE_LEN_DEF;
	localparam int DW = DATA_LEN_DEF;
	localparam int RANDOM_ITEMS = 650;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [CW-1:0] codeword;
	logic          done;
	logic [DW-1:0] data_word;
	logic [1:0]    status;
	int            fail_count;
	int            pending;

	hamming_secded_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.codeword  (codeword),
		.done      (done),
		.data_word (data_word),
		.status    (status)
	);

	hamming_secded_checker #(
		.CODE_LEN (CW),
		.DATA_LEN (DW)
	) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.codeword   (codeword),
		.done       (done),
		.data_word  (data_word),
		.status     (status),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// builds a clean codeword around a data word
	function automatic logic [CW-1:0] encode_word(input logic [DW-1:0] d);
		logic [CW-1:0] w;
		int            k;
		int            syn;
		w = '0;
		k = 0;
		syn = 0;
		for (int p = 1; p < CW; p++) begin
			if ((p & (p - 1)) != 0) begin
				if (k < DW) begin
					w[p] = d[k];
				end
				k++;
				if (w[p]) begin
					syn ^= p;
				end
			end
		end
		for (int b = 0; (1 << b) < CW; b++) begin
			w[1 << b] = syn[b];
		end
		w[0] = ^w[CW-1:1];
		return w;
	endfunction

	function automatic logic [DW-1:0] random_data();
		logic [63:0] r;
		int          pick;
		pick = $urandom_range(19);
		r = {$urandom, $urandom};
		if (pick == 0) begin
			r = '0;
		end else if (pick == 1) begin
			r = '1;
		end
		return r[DW-1:0];
	endfunction

	// one request, held until the block takes it
	task automatic send_request(input logic [CW-1:0] w);
		@(negedge clk);
		start <= 1'b1;
		codeword <= w;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 8);
	endfunction

	// run limit
	initial begin
		#10000000;
		$display("hamming_secded_decoder verification failed");
		$finish;
	end

	// stimulus and verdict
	initial begin
		logic [CW-1:0] w;
		logic [DW-1:0] pat;
		int            kind;
		int            a;
		int            b;
		bit            no_idle;
		arst_n = 1'b0;
		start = 1'b0;
		codeword = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part
		pat = random_data();
		send_request('0);
		send_request('1);
		send_request(encode_word('1));
		send_request(encode_word('0) ^ (64'd1 << 0));
		send_request(encode_word(pat) ^ (64'd1 << 1));
		send_request(encode_word(pat) ^ (64'd1 << 32));
		send_request(encode_word(pat) ^ (64'd1 << 3));
		send_request(encode_word(pat) ^ (64'd1 << 63));
		send_request(encode_word(pat) ^ (64'd1 << 5) ^ (64'd1 << 9));
		send_request(encode_word(pat) ^ (64'd1 << 0) ^ (64'd1 << 7));
		send_request(encode_word(pat) ^ (64'd1 << 1) ^ (64'd1 << 2));
		// three flips whose positions cancel in the syndrome
		send_request(encode_word(pat) ^ (64'd1 << 3) ^ (64'd1 << 5) ^ (64'd1 << 6));
		// three flips that look like a single data error
		send_request(encode_word(pat) ^ (64'd1 << 3) ^ (64'd1 << 5) ^ (64'd1 << 9));
		send_request(encode_word(DW'({29{2'b10}})));
		send_request(encode_word(DW'({29{2'b01}})) ^ (64'd1 << 62));
		send_request({$urandom, $urandom});
		send_request(encode_word('1) ^ (64'd1 << 48));

		// random part
		no_idle = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0) begin
				no_idle = ($urandom_range(2) == 0);
			end
			kind = $urandom_range(99);
			w = encode_word(random_data());
			a = $urandom_range(CW - 1);
			b = $urandom_range(CW - 1);
			while (b == a) begin
				b = $urandom_range(CW - 1);
			end
			if (kind < 20) begin
				w = {$urandom, $urandom};
			end else if (kind < 45) begin
				// clean word, left as is
			end else if (kind < 75) begin
				w[a] = ~w[a];
			end else if (kind < 95) begin
				w[a] = ~w[a];
				w[b] = ~w[b];
			end else begin
				w[a] = ~w[a];
				w[b] = ~w[b];
				w[$urandom_range(CW - 1)] ^= 1'b1;
			end
			send_request(w);
			if (!no_idle) begin
				idle_cycles(pick_gap());
			end
		end
		idle_cycles(1);

		// drain
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("hamming_secded_decoder verification clean");
		end else begin
			$display("hamming_secded_decoder verification failed");
		end
		$finish;
	end

endmodule

// File: hamming_secded_decoder.f
rtl/core/hsd_pkg.sv
rtl/core/hsd_fix.sv
rtl/core/hamming_secded_decoder.sv
verif/hamming_secded_checker.sv
verif/hamming_secded_decoder_test.sv
